// File: hw/rtl/matrix_multiply_assert.svh
// Assertion macros used by the matrix multiply RTL.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH
`ifndef ASSERT_OFF
`define MM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MM_ASSERT(lbl, prop, msg)
`define MM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hw/rtl/mm_pkg.sv
// Package for the matrix multiply block: field widths, codes and the sequencer state type.
// No dependencies; every other RTL file but the assertion header imports it.
package mm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int DIM_W       = 4;
	localparam int VAL_W       = 32;
	localparam int POS_W       = 3;
	localparam int ACT_W       = 2;
	localparam int REG_IDX_W   = 2;
	localparam int FRAC_W      = 16;

	localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_B_COLS = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_WAIT,
		ST_EMIT
	} mm_state_t;

endpackage

// File: hw/rtl/mm_if.sv
// Valid/ready channel interfaces for the matrix multiply block.
// Depends on mm_pkg for the field widths.
interface mm_in_if import mm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic [POS_W-1:0]        row_index;
	logic [POS_W-1:0]        col_index;
	logic signed [VAL_W-1:0] element_value;

	modport source (output valid, action, row_index, col_index, element_value, input ready);
	modport sink (input valid, action, row_index, col_index, element_value, output ready);
endinterface

interface mm_out_if import mm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] product_value;
	logic [POS_W-1:0]        out_row;
	logic [POS_W-1:0]        out_col;
	logic                    last_element;
	logic                    size_error;

	modport source (output valid, product_value, out_row, out_col, last_element, size_error,
		input ready);
	modport sink (input valid, product_value, out_row, out_col, last_element, size_error,
		output ready);
endinterface

// File: hw/rtl/mm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on mm_pkg for its default width and depth.
module mm_ram import mm_pkg::*; #(
	parameter int WIDTH = VAL_W,
	parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/matrix_multiply.sv
// Top level of the matrix multiply block: load stores for A and B, and a shared MAC sequencer.
// Depends on mm_pkg, mm_if.sv, mm_ram.sv and matrix_multiply_assert.svh.
//
// Usage. Registers a_rows, a_cols, b_rows and b_cols are written through the plain write port
// (cfg_wr_en, cfg_index, cfg_wdata); the user must write them only while the block is idle,
// which the block does not enforce. A written value is clamped to the range 1 to MAX_DIM.
// Each beat on the req channel is a load of one A element, a load of one B element, or a
// compute command. A load produces no result. A compute command streams every element of
// C = A x B on the rsp channel in row-major order, with last_element set on the final beat.
// When a_cols differs from b_rows a compute command yields one beat with size_error and
// last_element set and a zero value instead. Sequencing. One multiply-accumulate unit
// serves every product, so the elements of C are computed one after another: the sequencer
// issues a_cols store reads, then the registered store read, the registered product and the
// accumulate follow, and the sum is rounded and loaded into the output register. req.ready
// is low for a whole compute run.
// Stalls. Results sit in an output register; while rsp.ready is low the sequencer holds the
// next element at its rounding step, so no beat is lost or repeated.
// Reset. arst_n clears the sequencer and sets all four size registers to one. The stores are
// not cleared; every element must be loaded before a compute run reads it.
`include "matrix_multiply_assert.svh"

module matrix_multiply import mm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_wdata,
	mm_in_if.sink                req,
	mm_out_if.source             rsp
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Sum of up to MAX_DIM products of two signed 32-bit values stays exact in this width.
	localparam int ACC_W = 2 * VAL_W + IDX_W + 1;
	localparam int QW    = ACC_W - FRAC_W;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	// Size registers; values are clamped on write so every check sees a legal size.
	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] d;
		d = v;
		if (d == '0) begin
			d = DIM_W'(1);
		end
		if (d > DIM_MAX) begin
			d = DIM_MAX;
		end
		return d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_W'(1);
			a_cols_q <= DIM_W'(1);
			b_rows_q <= DIM_W'(1);
			b_cols_q <= DIM_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_A_ROWS: a_rows_q <= clamp_dim(cfg_wdata);
				REG_A_COLS: a_cols_q <= clamp_dim(cfg_wdata);
				REG_B_ROWS: b_rows_q <= clamp_dim(cfg_wdata);
				REG_B_COLS: b_cols_q <= clamp_dim(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Sequencer state and loop counters over row i, column j and inner index k.
	mm_state_t         state_q, state_d;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic              err_q;
	logic              acc_done_q;
	logic              rsp_vld_q;
	logic              issue, emit;

	logic req_fire, is_compute, size_mismatch, ld_in_range;
	logic k_last, j_last, i_last;

	assign req.ready     = (state_q == ST_IDLE);
	assign req_fire      = req.valid && req.ready;
	assign is_compute    = (req.action == ACT_COMPUTE);
	assign size_mismatch = (a_cols_q != b_rows_q);
	assign ld_in_range   = (DIM_W'(req.row_index) < DIM_MAX) && (DIM_W'(req.col_index) < DIM_MAX);

	assign k_last = ((DIM_W'(k_q) + DIM_W'(1)) == a_cols_q);
	assign j_last = ((DIM_W'(j_q) + DIM_W'(1)) == b_cols_q);
	assign i_last = ((DIM_W'(i_q) + DIM_W'(1)) == a_rows_q);

	// Store ports. Loads write only while idle, and compute only reads, so the ports never clash.
	logic [AW-1:0]    ld_addr, a_raddr, b_raddr;
	logic             a_we, b_we;
	logic [VAL_W-1:0] a_rd_s1, b_rd_s1;

	assign ld_addr = AW'(req.row_index[IDX_W-1:0]) * AW'(MAX_DIM) + AW'(req.col_index[IDX_W-1:0]);
	assign a_we    = req_fire && (req.action == ACT_LOAD_A) && ld_in_range;
	assign b_we    = req_fire && (req.action == ACT_LOAD_B) && ld_in_range;
	assign a_raddr = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
	assign b_raddr = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

	mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (ld_addr),
		.wdata (req.element_value),
		.raddr (a_raddr),
		.rdata (a_rd_s1)
	);

	mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (ld_addr),
		.wdata (req.element_value),
		.raddr (b_raddr),
		.rdata (b_rd_s1)
	);

	// Next state and control strobes.
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && is_compute) begin
					state_d = size_mismatch ? ST_EMIT : ST_MAC;
				end
			end
			ST_MAC: begin
				issue = 1'b1;
				if (k_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (acc_done_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!rsp_vld_q || rsp.ready) begin
					emit    = 1'b1;
					state_d = (err_q || (i_last && j_last)) ? ST_IDLE : ST_MAC;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
			err_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && req_fire && is_compute) begin
				i_q   <= '0;
				j_q   <= '0;
				k_q   <= '0;
				err_q <= size_mismatch;
			end
			if (issue) begin
				k_q <= k_last ? '0 : k_q + IDX_W'(1);
			end
			if (emit) begin
				err_q <= 1'b0;
				if (!err_q) begin
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + IDX_W'(1);
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
			end
		end
	end

	// MAC pipeline: registered store read, registered product, then the accumulator.
	logic vld_s1, first_s1, last_s1;
	logic vld_s2, first_s2, last_s2;
	logic signed [2*VAL_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]   acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			vld_s2     <= 1'b0;
			first_s2   <= 1'b0;
			last_s2    <= 1'b0;
			acc_done_q <= 1'b0;
		end else begin
			vld_s1   <= issue;
			first_s1 <= issue && (k_q == '0);
			last_s1  <= issue && k_last;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			if (vld_s2 && last_s2) begin
				acc_done_q <= 1'b1;
			end else if (state_q == ST_EMIT) begin
				acc_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rd_s1) * $signed(b_rd_s1);
		if (vld_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + ACC_W'(prod_s2);
		end
	end

	// Round toward zero: bias a negative sum by the fraction mask, then drop the fraction.
	// The quotient fits Q16.16 only when its bits from the sign bit of the result up agree.
	logic signed [ACC_W-1:0] rnd_sum;
	logic [QW-1:0]           quo;
	logic                    quo_fits;
	logic [VAL_W-1:0]        sat_value;

	assign rnd_sum  = acc_q + $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{acc_q[ACC_W-1]}}});
	assign quo      = rnd_sum[ACC_W-1:FRAC_W];
	assign quo_fits = (&quo[QW-1:VAL_W-1]) || !(|quo[QW-1:VAL_W-1]);
	assign sat_value = quo_fits ? quo[VAL_W-1:0]
		: (quo[QW-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

	// Output register.
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] row_q, col_q;
	logic             last_q, serr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (emit) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (err_q) begin
				val_q  <= '0;
				row_q  <= '0;
				col_q  <= '0;
				last_q <= 1'b1;
				serr_q <= 1'b1;
			end else begin
				val_q  <= sat_value;
				row_q  <= POS_W'(i_q);
				col_q  <= POS_W'(j_q);
				last_q <= i_last && j_last;
				serr_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.product_value = $signed(val_q);
	assign rsp.out_row       = row_q;
	assign rsp.out_col       = col_q;
	assign rsp.last_element  = last_q;
	assign rsp.size_error    = serr_q;

	// An error beat is always the single, final and zero-valued beat of its run.
	`MM_ASSERT(a_err_beat, rsp.valid && rsp.size_error |-> rsp.last_element && (rsp.product_value == '0), "size error beat is malformed")
	// Products are only in flight while the sequencer is issuing or draining.
	`MM_ASSERT(a_pipe_busy, (vld_s1 || vld_s2) |-> (state_q == ST_MAC) || (state_q == ST_WAIT), "MAC pipeline active outside compute")
	// The final product of an element always lands while the sequencer waits for it.
	`MM_ASSERT(a_last_in_wait, vld_s2 && last_s2 |-> (state_q == ST_WAIT), "final product arrived outside wait")
	// A stalled result holds the next element back at the rounding step.
	`MM_ASSERT(a_emit_holds, (state_q == ST_EMIT) && rsp.valid && !rsp.ready |=> (state_q == ST_EMIT), "element left emit while output stalled")
	// Size registers always hold a legal size.
	`MM_ASSERT(a_dims_legal, (a_rows_q != '0) && (a_rows_q <= DIM_MAX) && (a_cols_q != '0) && (a_cols_q <= DIM_MAX) && (b_rows_q != '0) && (b_rows_q <= DIM_MAX) && (b_cols_q != '0) && (b_cols_q <= DIM_MAX), "size register out of range")

endmodule
